// ===== rtl/world_to_screen_projection_macros.svh =====
// Assertion macros shared by the world-to-screen projection design.
`ifndef WORLD_TO_SCREEN_PROJECTION_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_MACROS_SVH

// Checked on every clock edge outside reset.
`define WTSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define WTSP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/wtsp_pkg.sv =====
// Shared types and constants of the world-to-screen projection block.
package wtsp_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int COORD_W           = 32;
   localparam int PROD_W            = 2 * COORD_W;
   localparam int COEF_IDX_W        = 4;
   localparam int COEF_COUNT        = 16;
   localparam int VP_W              = 14;
   localparam int CSR_IDX_W         = 2;
   localparam int NDC_OVF_SHIFT     = 25;

   localparam logic [VP_W-1:0] VP_WIDTH_RESET  = VP_W'(640);
   localparam logic [VP_W-1:0] VP_HEIGHT_RESET = VP_W'(480);

   typedef enum logic {
      ACTION_LOAD    = 1'b0,
      ACTION_PROJECT = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIEWPORT_WIDTH  = 2'd0,
      CSR_VIEWPORT_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic visible;
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
   } div_side_type;

endpackage

// ===== rtl/wtsp_req_if.sv =====
// Request channel: load and project items.
interface wtsp_req_if import wtsp_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [COEF_IDX_W-1:0]     coef_index;
   logic signed [COORD_W-1:0] coef_value;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;

   modport source (output valid, action, coef_index, coef_value, pos_x, pos_y, pos_z,
                   input ready);
   modport sink (input valid, action, coef_index, coef_value, pos_x, pos_y, pos_z,
                 output ready);
endinterface

// ===== rtl/wtsp_rsp_if.sv =====
// Response channel: projected screen points.
interface wtsp_rsp_if import wtsp_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      visible;
   logic signed [COORD_W-1:0] screen_x;
   logic signed [COORD_W-1:0] screen_y;

   modport source (output valid, visible, screen_x, screen_y, input ready);
   modport sink (input valid, visible, screen_x, screen_y, output ready);
endinterface

// ===== rtl/world_to_screen_projection.sv =====
// Top level of the world-to-screen projection pipeline.
//
//  channel  direction  handshake        payload
//  req_ch   in         valid / ready    action, coef_index, coef_value, pos_x/y/z
//  rsp_ch   out        valid / ready    visible, screen_x, screen_y
//  csr_*    in         write enable     csr_index, csr_write_data
//
// One item is taken per cycle while the result is taken or absent; a project item passes
// FRAC_BITS + 32 register stages (48 for Q16.16) before its result is offered.
// Most of the stages are the divider, which resolves one quotient bit per stage.
// Load items update the matrix at acceptance and give no result.
// Reset is synchronous, clears the matrix and all valid bits and sets the viewport to 640 by 480.
// When the result is not taken, the whole pipeline holds and req_ch.ready falls.
`include "world_to_screen_projection_macros.svh"

module world_to_screen_projection import wtsp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   wtsp_req_if.sink              req_ch,
   wtsp_rsp_if.source            rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [VP_W-1:0]       csr_write_data
);

   localparam int CLIP_W  = PROD_W + 2 - FRAC_BITS;
   localparam int QUOT_W  = NDC_OVF_SHIFT + FRAC_BITS;
   localparam int NDC_W   = QUOT_W + 2;
   localparam int HALF_W  = VP_W - 1;
   localparam int VPROD_W = NDC_W + HALF_W + 1;
   localparam int SUM_W   = VPROD_W + 1;
   localparam logic signed [CLIP_W-1:0] THRESH = CLIP_W'((2 ** FRAC_BITS + 9) / 10);

   logic [VP_W-1:0]   vp_width_ff;
   logic [VP_W-1:0]   vp_height_ff;
   logic [COORD_W-1:0] matrix_ff [COEF_COUNT];
   logic              advance;
   logic              accept;
   logic [HALF_W-1:0] half_w;
   logic [HALF_W-1:0] half_h;

   assign advance       = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready  = advance;
   assign accept        = req_ch.valid && advance;
   assign half_w        = vp_width_ff[VP_W-1:1];
   assign half_h        = vp_height_ff[VP_W-1:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_width_ff  <= VP_WIDTH_RESET;
         vp_height_ff <= VP_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_VIEWPORT_WIDTH:  vp_width_ff  <= csr_write_data;
            CSR_VIEWPORT_HEIGHT: vp_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_COUNT; i++) begin
            matrix_ff[i] <= '0;
         end
      end else if (accept && action_type'(req_ch.action) == ACTION_LOAD) begin
         matrix_ff[req_ch.coef_index] <= req_ch.coef_value;
      end
   end

   // Stage 1: nine products of the point with rows x, y and w.
   logic                      s1_valid_ff;
   logic signed [PROD_W-1:0]  prod_ff [3][3];
   logic signed [COORD_W-1:0] trans_ff [3];
   logic signed [COORD_W-1:0] pos [3];

   assign pos[0] = req_ch.pos_x;
   assign pos[1] = req_ch.pos_y;
   assign pos[2] = req_ch.pos_z;

   for (genvar r = 0; r < 3; r++) begin : g_row
      localparam int ROW = (r == 2) ? 3 : r;
      for (genvar c = 0; c < 3; c++) begin : g_col
         always_ff @(posedge clock) begin
            if (advance) begin
               prod_ff[r][c] <= pos[c] * $signed(matrix_ff[ROW*4+c]);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            trans_ff[r] <= $signed(matrix_ff[ROW*4+3]);
         end
      end
   end

   // Stage 2 and 3: floored products summed with the translation term.
   logic                      s2_valid_ff;
   logic signed [CLIP_W-1:0]  pair_a_ff [3];
   logic signed [CLIP_W-1:0]  pair_b_ff [3];
   logic                      s3_valid_ff;
   logic signed [CLIP_W-1:0]  clip_ff [3];

   for (genvar r = 0; r < 3; r++) begin : g_sum
      logic signed [CLIP_W-1:0] fl0;
      logic signed [CLIP_W-1:0] fl1;
      logic signed [CLIP_W-1:0] fl2;
      logic signed [CLIP_W-1:0] tr;
      assign fl0 = {{2{prod_ff[r][0][PROD_W-1]}}, prod_ff[r][0][PROD_W-1:FRAC_BITS]};
      assign fl1 = {{2{prod_ff[r][1][PROD_W-1]}}, prod_ff[r][1][PROD_W-1:FRAC_BITS]};
      assign fl2 = {{2{prod_ff[r][2][PROD_W-1]}}, prod_ff[r][2][PROD_W-1:FRAC_BITS]};
      assign tr  = {{(CLIP_W-COORD_W){trans_ff[r][COORD_W-1]}}, trans_ff[r]};
      always_ff @(posedge clock) begin
         if (advance) begin
            pair_a_ff[r] <= fl0 + fl1;
            pair_b_ff[r] <= fl2 + tr;
            clip_ff[r]   <= pair_a_ff[r] + pair_b_ff[r];
         end
      end
   end

   // Stage 4: visibility, magnitudes and divider set-up.
   logic                 s4_valid_ff;
   logic [CLIP_W-1:0]    abs_x;
   logic [CLIP_W-1:0]    abs_y;
   logic [CLIP_W-1:0]    w_bits;
   div_side_type         side_in;
   logic [CLIP_W-1:0]    w_ff;
   logic [CLIP_W-1:0]    rem_x_ff;
   logic [CLIP_W-1:0]    rem_y_ff;
   logic [QUOT_W-1:0]    nq_x_ff;
   logic [QUOT_W-1:0]    nq_y_ff;
   div_side_type         side_ff;

   assign w_bits  = clip_ff[2];
   assign abs_x   = clip_ff[0][CLIP_W-1] ? CLIP_W'(-clip_ff[0]) : clip_ff[0];
   assign abs_y   = clip_ff[1][CLIP_W-1] ? CLIP_W'(-clip_ff[1]) : clip_ff[1];

   always_comb begin
      side_in.visible = clip_ff[2] >= THRESH;
      side_in.neg_x   = clip_ff[0][CLIP_W-1];
      side_in.neg_y   = clip_ff[1][CLIP_W-1];
      side_in.ovf_x   = {{NDC_OVF_SHIFT{1'b0}}, abs_x} >= {w_bits, {NDC_OVF_SHIFT{1'b0}}};
      side_in.ovf_y   = {{NDC_OVF_SHIFT{1'b0}}, abs_y} >= {w_bits, {NDC_OVF_SHIFT{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         w_ff     <= w_bits;
         rem_x_ff <= abs_x >> NDC_OVF_SHIFT;
         rem_y_ff <= abs_y >> NDC_OVF_SHIFT;
         nq_x_ff  <= {abs_x[NDC_OVF_SHIFT-1:0], {FRAC_BITS{1'b0}}};
         nq_y_ff  <= {abs_y[NDC_OVF_SHIFT-1:0], {FRAC_BITS{1'b0}}};
         side_ff  <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && action_type'(req_ch.action) == ACTION_PROJECT;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   logic              div_valid;
   logic [CLIP_W-1:0] div_rem_x;
   logic [CLIP_W-1:0] div_rem_y;
   logic [QUOT_W-1:0] div_quot_x;
   logic [QUOT_W-1:0] div_quot_y;
   div_side_type      div_side;

   wtsp_divider #(
      .CW (CLIP_W),
      .QW (QUOT_W)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (s4_valid_ff),
      .in_w       (w_ff),
      .in_rem_x   (rem_x_ff),
      .in_nq_x    (nq_x_ff),
      .in_rem_y   (rem_y_ff),
      .in_nq_y    (nq_y_ff),
      .in_side    (side_ff),
      .out_valid  (div_valid),
      .out_rem_x  (div_rem_x),
      .out_quot_x (div_quot_x),
      .out_rem_y  (div_rem_y),
      .out_quot_y (div_quot_y),
      .out_side   (div_side)
   );

   // Stage 5: signed floor quotient, clamped far beyond the saturation range.
   localparam logic signed [NDC_W-1:0] NDC_BIG = NDC_W'(1) << QUOT_W;

   logic                     s5_valid_ff;
   logic                     s5_visible_ff;
   logic signed [NDC_W-1:0]  ndc_x_ff;
   logic signed [NDC_W-1:0]  ndc_y_ff;
   logic signed [NDC_W-1:0]  ndc_x_in;
   logic signed [NDC_W-1:0]  ndc_y_in;
   logic signed [NDC_W-1:0]  qx;
   logic signed [NDC_W-1:0]  qy;

   assign qx = NDC_W'(div_quot_x);
   assign qy = NDC_W'(div_quot_y);

   always_comb begin
      if (div_side.ovf_x) begin
         ndc_x_in = div_side.neg_x ? -NDC_BIG : NDC_BIG;
      end else if (div_side.neg_x) begin
         ndc_x_in = -qx - NDC_W'(div_rem_x != '0);
      end else begin
         ndc_x_in = qx;
      end
      if (div_side.ovf_y) begin
         ndc_y_in = div_side.neg_y ? -NDC_BIG : NDC_BIG;
      end else if (div_side.neg_y) begin
         ndc_y_in = -qy - NDC_W'(div_rem_y != '0);
      end else begin
         ndc_y_in = qy;
      end
   end

   // Stage 6: viewport products.
   logic                      s6_valid_ff;
   logic                      s6_visible_ff;
   logic signed [VPROD_W-1:0] vprod_x_ff;
   logic signed [VPROD_W-1:0] vprod_y_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         ndc_x_ff      <= ndc_x_in;
         ndc_y_ff      <= ndc_y_in;
         s5_visible_ff <= div_side.visible;
         vprod_x_ff    <= $signed({1'b0, half_w}) * ndc_x_ff;
         vprod_y_ff    <= $signed({1'b0, half_h}) * ndc_y_ff;
         s6_visible_ff <= s5_visible_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= div_valid;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // Output register: offset by the half size and saturate.
   logic [SUM_W-1:0]          sum_x;
   logic [SUM_W-1:0]          sum_y;
   logic                      ovf_sx;
   logic                      ovf_sy;
   logic [COORD_W-1:0]        sat_x;
   logic [COORD_W-1:0]        sat_y;
   logic                      rsp_valid_ff;
   logic                      rsp_visible_ff;
   logic [COORD_W-1:0]        rsp_x_ff;
   logic [COORD_W-1:0]        rsp_y_ff;

   assign sum_x  = SUM_W'(vprod_x_ff) + (SUM_W'(half_w) << FRAC_BITS);
   assign sum_y  = (SUM_W'(half_h) << FRAC_BITS) - SUM_W'(vprod_y_ff);
   assign ovf_sx = !((&sum_x[SUM_W-1:COORD_W-1]) || !(|sum_x[SUM_W-1:COORD_W-1]));
   assign ovf_sy = !((&sum_y[SUM_W-1:COORD_W-1]) || !(|sum_y[SUM_W-1:COORD_W-1]));
   assign sat_x  = ovf_sx ? {sum_x[SUM_W-1], {(COORD_W-1){!sum_x[SUM_W-1]}}}
                          : sum_x[COORD_W-1:0];
   assign sat_y  = ovf_sy ? {sum_y[SUM_W-1], {(COORD_W-1){!sum_y[SUM_W-1]}}}
                          : sum_y[COORD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_visible_ff <= s6_visible_ff;
         rsp_x_ff       <= s6_visible_ff ? sat_x : '0;
         rsp_y_ff       <= s6_visible_ff ? sat_y : '0;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.visible  = rsp_visible_ff;
   assign rsp_ch.screen_x = rsp_x_ff;
   assign rsp_ch.screen_y = rsp_y_ff;

   `WTSP_ASSERT(a_hidden_is_zero, clock, reset, rsp_ch.valid && !rsp_ch.visible |-> rsp_ch.screen_x == '0 && rsp_ch.screen_y == '0, "Hidden item carries a non-zero position.")
   `WTSP_ASSERT_ALWAYS(a_reset_empties, clock, $past(reset) |-> !rsp_ch.valid, "Result valid straight after reset.")
   `WTSP_ASSERT(a_stall_holds_divider, clock, reset, !advance |=> $stable(div_valid) && $stable(div_quot_x), "Divider moved during a stall.")
   `WTSP_ASSERT(a_zero_half_width, clock, reset, rsp_ch.valid && half_w == '0 |-> rsp_ch.screen_x == '0, "Zero half width gave a non-zero x.")

endmodule

// ===== rtl/wtsp_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
module wtsp_divider import wtsp_pkg::*; #(
   parameter int CW = PROD_W + 2 - FRAC_BITS_DEFAULT,
   parameter int QW = NDC_OVF_SHIFT + FRAC_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           in_valid,
   input  logic [CW-1:0]  in_w,
   input  logic [CW-1:0]  in_rem_x,
   input  logic [QW-1:0]  in_nq_x,
   input  logic [CW-1:0]  in_rem_y,
   input  logic [QW-1:0]  in_nq_y,
   input  div_side_type   in_side,
   output logic           out_valid,
   output logic [CW-1:0]  out_rem_x,
   output logic [QW-1:0]  out_quot_x,
   output logic [CW-1:0]  out_rem_y,
   output logic [QW-1:0]  out_quot_y,
   output div_side_type   out_side
);

   logic               valid_ff [QW];
   logic [CW-1:0]      w_ff     [QW];
   logic [CW-1:0]      rem_x_ff [QW];
   logic [QW-1:0]      nq_x_ff  [QW];
   logic [CW-1:0]      rem_y_ff [QW];
   logic [QW-1:0]      nq_y_ff  [QW];
   div_side_type       side_ff  [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          valid_src;
      logic [CW-1:0] w_src;
      logic [CW-1:0] rem_x_src;
      logic [QW-1:0] nq_x_src;
      logic [CW-1:0] rem_y_src;
      logic [QW-1:0] nq_y_src;
      div_side_type  side_src;
      logic [CW:0]   trial_x;
      logic [CW:0]   trial_y;
      logic          ge_x;
      logic          ge_y;
      logic [CW-1:0] rem_x_in;
      logic [CW-1:0] rem_y_in;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign w_src     = in_w;
         assign rem_x_src = in_rem_x;
         assign nq_x_src  = in_nq_x;
         assign rem_y_src = in_rem_y;
         assign nq_y_src  = in_nq_y;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign w_src     = w_ff[k-1];
         assign rem_x_src = rem_x_ff[k-1];
         assign nq_x_src  = nq_x_ff[k-1];
         assign rem_y_src = rem_y_ff[k-1];
         assign nq_y_src  = nq_y_ff[k-1];
         assign side_src  = side_ff[k-1];
      end

      assign trial_x  = {rem_x_src, nq_x_src[QW-1]};
      assign trial_y  = {rem_y_src, nq_y_src[QW-1]};
      assign ge_x     = trial_x >= {1'b0, w_src};
      assign ge_y     = trial_y >= {1'b0, w_src};
      assign rem_x_in = ge_x ? CW'(trial_x - {1'b0, w_src}) : trial_x[CW-1:0];
      assign rem_y_in = ge_y ? CW'(trial_y - {1'b0, w_src}) : trial_y[CW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            w_ff[k]     <= w_src;
            rem_x_ff[k] <= rem_x_in;
            nq_x_ff[k]  <= {nq_x_src[QW-2:0], ge_x};
            rem_y_ff[k] <= rem_y_in;
            nq_y_ff[k]  <= {nq_y_src[QW-2:0], ge_y};
            side_ff[k]  <= side_src;
         end
      end
   end

   assign out_valid  = valid_ff[QW-1];
   assign out_rem_x  = rem_x_ff[QW-1];
   assign out_quot_x = nq_x_ff[QW-1];
   assign out_rem_y  = rem_y_ff[QW-1];
   assign out_quot_y = nq_y_ff[QW-1];
   assign out_side   = side_ff[QW-1];

endmodule

// ===== test/world_to_screen_projection_tb.sv =====
// Testbench for the world-to-screen projection block, checked against a predictor.
module world_to_screen_projection_tb;
   import wtsp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = FRAC_BITS_DEFAULT;
   localparam int DRAIN_CYCLES = FB + 32 + 16;

   typedef struct {
      logic           visible;
      logic [31:0]    screen_x;
      logic [31:0]    screen_y;
   } screen_point_type;

   typedef struct {
      action_type       action;
      logic [3:0]       idx;
      logic [31:0]      value;
      logic [31:0]      x;
      logic [31:0]      y;
      logic [31:0]      z;
      bit               typed;
      screen_point_type point;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VP_W-1:0] csr_write_data = '0;

   wtsp_req_if req ();
   wtsp_rsp_if rsp ();

   world_to_screen_projection dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req),
      .rsp_ch           (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   logic [31:0]      matrix_shadow [16];
   logic [VP_W-1:0]  width_shadow;
   logic [VP_W-1:0]  height_shadow;
   screen_point_type pending_points [$];
   int               failures = 0;
   int               gap_pct = 0;
   int               stall_pct = 0;

   function automatic longint row_sum(int r, longint px, longint py, longint pz);
      longint m0, m1, m2, m3;
      m0 = longint'(signed'(matrix_shadow[r*4]));
      m1 = longint'(signed'(matrix_shadow[r*4+1]));
      m2 = longint'(signed'(matrix_shadow[r*4+2]));
      m3 = longint'(signed'(matrix_shadow[r*4+3]));
      return ((px * m0) >>> FB) + ((py * m1) >>> FB) + ((pz * m2) >>> FB) + m3;
   endfunction

   function automatic longint ndc_of(longint a, longint w);
      longint q, r, frac;
      q = a / w;
      r = a % w;
      frac = 0;
      if (r < 0) begin
         q = q - 1;
         r = r + w;
      end
      if (q > (64'sd1 <<< 24)) q = 64'sd1 <<< 24;
      if (q < -(64'sd1 <<< 24)) q = -(64'sd1 <<< 24);
      for (int i = 0; i < FB; i++) begin
         r = r <<< 1;
         frac = frac <<< 1;
         if (r >= w) begin
            r = r - w;
            frac = frac | 1;
         end
      end
      return q * (64'sd1 <<< FB) + frac;
   endfunction

   function automatic logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic screen_point_type project_point(logic [31:0] x, logic [31:0] y,
                                                      logic [31:0] z);
      screen_point_type p;
      longint px, py, pz, cx, cy, cw, hw, hh, one, nx, ny;
      px = longint'(signed'(x));
      py = longint'(signed'(y));
      pz = longint'(signed'(z));
      cx = row_sum(0, px, py, pz);
      cy = row_sum(1, px, py, pz);
      cw = row_sum(3, px, py, pz);
      one = 64'sd1 <<< FB;
      p = '{1'b0, 32'd0, 32'd0};
      if (cw < (one + 9) / 10) return p;
      nx = ndc_of(cx, cw);
      ny = ndc_of(cy, cw);
      hw = longint'(width_shadow >> 1);
      hh = longint'(height_shadow >> 1);
      p.visible = 1'b1;
      p.screen_x = sat32(hw * nx + hw * one);
      p.screen_y = sat32(-(hh * ny) + hh * one);
      return p;
   endfunction

   task automatic send(stim_row_type s);
      while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.action <= s.action;
      req.coef_index <= s.idx;
      req.coef_value <= s.value;
      req.pos_x <= s.x;
      req.pos_y <= s.y;
      req.pos_z <= s.z;
      do @(posedge clock); while (!req.ready);
      if (s.action == ACTION_LOAD)
         matrix_shadow[s.idx] = s.value;
      else if (s.typed)
         pending_points.push_back(s.point);
      else
         pending_points.push_back(project_point(s.x, s.y, s.z));
   endtask

   task automatic write_csr(csr_index_type idx, logic [VP_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_VIEWPORT_WIDTH) width_shadow = data;
      else if (idx == CSR_VIEWPORT_HEIGHT) height_shadow = data;
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_points.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rnd_coord();
      case ($urandom_range(4))
         0: return $urandom;
         1: return 32'($urandom_range(16 << FB)) - 32'(8 << FB);
         2: begin
            case ($urandom_range(4))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0;
               3: return 32'h1;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return 32'($urandom_range(2048)) - 32'd1024;
      endcase
   endfunction

   function automatic stim_row_type load_row(int idx, logic [31:0] value);
      stim_row_type s;
      s = '{ACTION_LOAD, 4'(idx), value, $urandom, $urandom, $urandom, 1'b0,
            '{1'b0, 32'd0, 32'd0}};
      return s;
   endfunction

   function automatic stim_row_type proj_row(logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z);
      stim_row_type s;
      s = '{ACTION_PROJECT, 4'($urandom), $urandom, x, y, z, 1'b0,
            '{1'b0, 32'd0, 32'd0}};
      return s;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_points.size() == 0) begin
            $error("unexpected item: visible %0b x %h y %h",
                   rsp.visible, rsp.screen_x, rsp.screen_y);
            failures++;
         end else begin
            screen_point_type e;
            e = pending_points.pop_front();
            if (rsp.visible !== e.visible) begin
               $error("visible: expected %0b actual %0b", e.visible, rsp.visible);
               failures++;
            end
            if (rsp.screen_x !== e.screen_x) begin
               $error("screen_x: expected %h actual %h", e.screen_x, rsp.screen_x);
               failures++;
            end
            if (rsp.screen_y !== e.screen_y) begin
               $error("screen_y: expected %h actual %h", e.screen_y, rsp.screen_y);
               failures++;
            end
         end
      end
      rsp.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #2000000;
      $display("FAIL world_to_screen_projection");
      $finish;
   end

   initial begin
      stim_row_type dir_tab [$];
      int phase_gap [6];
      int phase_stall [6];
      logic [VP_W-1:0] phase_w [6];
      logic [VP_W-1:0] phase_h [6];
      int sent;

      phase_gap = '{0, 75, 0, 13, 0, 75};
      phase_stall = '{0, 0, 75, 13, 0, 75};
      phase_w = '{14'd1, 14'd8192, 14'd16383, 14'd0, 14'd641, 14'd2};
      phase_h = '{14'd8192, 14'd1, 14'd0, 14'd16383, 14'd479, 14'd3};
      req.valid = 1'b0;
      req.action = ACTION_LOAD;
      req.coef_index = '0;
      req.coef_value = '0;
      req.pos_x = '0;
      req.pos_y = '0;
      req.pos_z = '0;
      rsp.ready = 1'b0;
      foreach (matrix_shadow[i]) matrix_shadow[i] = '0;
      width_shadow = VP_WIDTH_RESET;
      height_shadow = VP_HEIGHT_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero matrix after reset: w is zero, so the point is not visible.
      dir_tab.push_back('{ACTION_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
                          '{1'b0, 32'd0, 32'd0}});
      dir_tab.push_back(load_row(0, 32'h0001_0000));
      dir_tab.push_back(load_row(5, 32'h0001_0000));
      dir_tab.push_back(load_row(15, 32'h0001_0000));
      // Identity matrix with the reset viewport: the origin lands at the centre.
      dir_tab.push_back('{ACTION_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
                          '{1'b1, 32'd320 << 16, 32'd240 << 16}});
      dir_tab.push_back('{ACTION_PROJECT, 4'd0, 32'd0, 32'h0001_0000, 32'h0001_0000, 32'd0,
                          1'b1, '{1'b1, 32'd640 << 16, 32'd0}});
      dir_tab.push_back(proj_row(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
      dir_tab.push_back(proj_row(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
      // Clip w one step below the 0.1 threshold, then exactly on it.
      dir_tab.push_back(load_row(15, 32'd6553));
      dir_tab.push_back('{ACTION_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
                          '{1'b0, 32'd0, 32'd0}});
      dir_tab.push_back(load_row(15, 32'd6554));
      dir_tab.push_back(proj_row(32'h0001_0000, 32'hffff_0000, 32'd0));
      dir_tab.push_back(proj_row(32'h7fff_ffff, 32'h8000_0000, 32'd0));
      dir_tab.push_back(load_row(3, 32'h7fff_ffff));
      dir_tab.push_back(load_row(7, 32'h8000_0000));
      dir_tab.push_back(load_row(14, 32'h8000_0000));
      dir_tab.push_back(proj_row(32'd0, 32'd0, 32'h8000_0000));
      dir_tab.push_back(proj_row(32'd0, 32'd0, 32'h7fff_ffff));
      dir_tab.push_back(load_row(12, 32'h7fff_ffff));
      dir_tab.push_back(proj_row(32'h0000_0001, 32'hffff_ffff, 32'h0000_0000));
      dir_tab.push_back(proj_row(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff));
      foreach (dir_tab[i]) send(dir_tab[i]);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_VIEWPORT_WIDTH, phase_w[ph]);
         write_csr(CSR_VIEWPORT_HEIGHT, phase_h[ph]);
         write_csr(csr_index_type'(2), 14'($urandom));
         write_csr(csr_index_type'(3), 14'($urandom));
         gap_pct = phase_gap[ph];
         stall_pct = phase_stall[ph];
         sent = 0;
         while (sent < 225) begin
            if ($urandom_range(9) == 0) begin
               if ($urandom_range(1)) send(load_row($urandom_range(15), rnd_coord()));
               else send(proj_row(rnd_coord(), rnd_coord(), rnd_coord()));
               sent++;
            end else begin
               for (int i = 0; i < 16; i++) begin
                  logic [31:0] v;
                  if (i < 12 || $urandom_range(7) == 0) v = rnd_coord();
                  else if (i < 15) v = 32'($urandom_range(4096)) - 32'd2048;
                  else v = 32'($urandom_range(4 << FB, 6000));
                  send(load_row(i, v));
               end
               sent += 16;
               for (int n = $urandom_range(12, 1); n > 0; n--) begin
                  if ($urandom_range(3) == 0)
                     send(proj_row(rnd_coord(), rnd_coord(), rnd_coord()));
                  else
                     send(proj_row(32'($urandom_range(32 << FB)) - 32'(16 << FB),
                                   32'($urandom_range(32 << FB)) - 32'(16 << FB),
                                   32'($urandom_range(32 << FB)) - 32'(16 << FB)));
                  sent++;
               end
            end
         end
         drain();
      end

      if (failures == 0)
         $display("PASS world_to_screen_projection");
      else
         $display("FAIL world_to_screen_projection");
      $finish;
   end

endmodule
